>>> src/aes_pkg.sv
// shared types, tables and round functions for the aes-128 ctr block
package aes_pkg;

  localparam int BlockBytes = 16;
  localparam int Rounds = 10;
  localparam int RegIdxW = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_CTR_HIGH = 2'd2,
    REG_CTR_LOW  = 2'd3
  } reg_idx_t;

  // payload carried alongside the cipher state through the cell chain
  typedef struct packed {
    logic [127:0] data;
    logic [4:0]   nbytes;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // subbytes, shiftrows and, unless last, mixcolumns
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = sbox(byte_at(s, ((c + i) % 4) * 4 + i));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4+1];
      a2 = t[c*4+2];
      a3 = t[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        o[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end else begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end
    end
    return o;
  endfunction

endpackage

>>> src/aes128_ctr_block_cipher_top.sv
// top level of the aes-128 ctr block cipher engine
// usage:
//  - cfg port writes key_high, key_low, counter_init_high, counter_init_low
//    (index 0..3) while the engine is idle; other indexes are ignored
//  - in_tdata: data_high, data_low, valid_bytes; in_tuser: first_block
//    first_block reloads the counter from the init registers for this item
//  - out_tdata: result_high, result_low, result_bytes; bytes past the valid
//    count read as zero, counts above sixteen saturate to sixteen
// throughput: one item per cycle unless the output stalls, set by a chain
//   of ten round cells that each hold one aes round plus its round key, so
//   the key schedule flows with the data and needs no stored table
// path: an accepted item passes the input cell, ten round cells and the
//   output register on its way to out_tvalid
// stalls: when out_tready is low and the output slot is full the whole chain holds;
//   in_tready follows out_tready or an empty output slot, so an output-slot bubble is squeezed out
// reset: counter, key and init registers clear to zero, the chain empties
module aes128_ctr_block_cipher_top #(
  parameter int NUM_ROUNDS = aes_pkg::Rounds
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // data_high [63:0], data_low [127:64], valid_bytes [132:128], zero pad
  input  logic [135:0] in_tdata,
  // first_block [0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_high [63:0], result_low [127:64], result_bytes [132:128], zero pad
  output logic [135:0] out_tdata
);
  logic [127:0] key_r, ctr_init_r, ctr_r, ctr_nxt;
  logic         adv;
  logic         acc;

  // chain taps: index 0 is the input cell after round-key zero
  logic           vld [NUM_ROUNDS+1];
  logic [127:0]   st  [NUM_ROUNDS+1];
  logic [127:0]   rk  [NUM_ROUNDS+1];
  aes_pkg::side_t sd  [NUM_ROUNDS+1];

  logic         ov_r;
  logic [135:0] od_r;

  assign adv       = out_tready || !ov_r;
  assign in_tready = adv;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      ctr_init_r <= '0;
    end else if (cfg_we) begin
      unique case (aes_pkg::reg_idx_t'(cfg_idx))
        aes_pkg::REG_KEY_HIGH: key_r[127:64]      <= cfg_data;
        aes_pkg::REG_KEY_LOW:  key_r[63:0]        <= cfg_data;
        aes_pkg::REG_CTR_HIGH: ctr_init_r[127:64] <= cfg_data;
        aes_pkg::REG_CTR_LOW:  ctr_init_r[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [127:0] ctr_use;
  logic [4:0]   nb;
  assign ctr_use = in_tuser ? ctr_init_r : ctr_r;
  assign ctr_nxt = ctr_use + 128'd1;
  // saturate counts above sixteen
  assign nb = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];

  logic           vld0_r;
  logic [127:0]   st0_r, rk0_r;
  aes_pkg::side_t sd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r  <= '0;
      vld0_r <= 1'b0;
    end else begin
      if (acc) ctr_r <= ctr_nxt;
      if (adv) vld0_r <= acc;
    end
    if (adv) begin
      st0_r <= ctr_use ^ key_r;
      rk0_r <= key_r;
      // block byte 0 is data_high msb: data occupies {high, low}
      sd0_r <= '{data: {in_tdata[63:0], in_tdata[127:64]}, nbytes: nb};
    end
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = rk0_r;
  assign sd[0]  = sd0_r;

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    aes_round_cell #(.ROUND(4'(g)), .NUM_ROUNDS(NUM_ROUNDS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .vld_i  (vld[g-1]),
      .st_i   (st[g-1]),
      .key_i  (rk[g-1]),
      .side_i (sd[g-1]),
      .vld_o  (vld[g]),
      .st_o   (st[g]),
      .key_o  (rk[g]),
      .side_o (sd[g])
    );
  end

  // keep mask: byte i kept when i < count
  logic [127:0] mask, xr;
  always_comb begin
    for (int i = 0; i < aes_pkg::BlockBytes; i++) begin
      mask[127-8*i -: 8] = (5'(i) < sd[NUM_ROUNDS].nbytes) ? 8'hff : 8'h00;
    end
  end
  assign xr = (sd[NUM_ROUNDS].data ^ st[NUM_ROUNDS]) & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vld[NUM_ROUNDS];
    end
    if (adv) begin
      od_r <= {3'b000, sd[NUM_ROUNDS].nbytes, xr[63:0], xr[127:64]};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed under stall");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[132:128] <= 5'd16)
    else $error("result count above sixteen");
  a_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ctr_r == $past(ctr_nxt))
    else $error("counter did not advance");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctr_r))
    else $error("counter moved while stalled");
endmodule

>>> src/aes_round_cell.sv
// one aes round cell: state, payload and running round key advance together
module aes_round_cell #(
  parameter logic [3:0] ROUND      = 4'd1,
  parameter int         NUM_ROUNDS = aes_pkg::Rounds
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld_i,
  input  logic [127:0]    st_i,
  input  logic [127:0]    key_i,
  input  aes_pkg::side_t  side_i,
  output logic            vld_o,
  output logic [127:0]    st_o,
  output logic [127:0]    key_o,
  output aes_pkg::side_t  side_o
);
  logic            vld_r;
  logic [127:0]    st_r, key_r;
  aes_pkg::side_t  side_r;
  logic [127:0]    key_nxt;

  assign key_nxt = aes_pkg::next_key(key_i, ROUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      st_r   <= aes_pkg::round_fn(st_i, ROUND == 4'(NUM_ROUNDS)) ^ key_nxt;
      key_r  <= key_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign st_o   = st_r;
  assign key_o  = key_r;
  assign side_o = side_r;
endmodule

>>> bench/aes128_ctr_block_cipher_top_tb.sv
// testbench for the aes-128 ctr block cipher engine: predictor, driver, monitor, checks
module aes128_ctr_block_cipher_top_tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = '0;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // data_high [63:0], data_low [127:64], valid_bytes [132:128], zero pad
  logic [135:0] in_tdata = '0;
  // first_block [0]
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // result_high [63:0], result_low [127:64], result_bytes [132:128], zero pad
  logic [135:0] out_tdata;

  aes128_ctr_block_cipher_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic [135:0] data;
    logic         first;
  } blk_t;

  // shadow state of the engine
  logic [63:0]  key_hi, key_lo, ctr_init_hi, ctr_init_lo;
  logic [127:0] ctr;

  blk_t         pending_blocks[$];
  logic [135:0] expected_results[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           idle_cycles = 0;
  bit           hold_off = 1'b0;
  bit           timed_out = 1'b0;

  // s-box built from the multiplicative inverse and affine map, own derivation
  logic [7:0] sb [256];

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] mul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] a, int n);
    return (a << n) | (a >> (8 - n));
  endfunction

  // fips-197 keystream block for one counter value
  function automatic logic [127:0] keystream(logic [127:0] key, logic [127:0] cnt);
    logic [7:0]   st [16];
    logic [7:0]   sh [16];
    logic [127:0] rk;
    logic [31:0]  t;
    logic [7:0]   rc;
    logic [127:0] o;
    rk = key;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) st[i] = cnt[127-8*i -: 8] ^ rk[127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      // key schedule for this round
      t = rk[31:0];
      t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
      rk[127:96] ^= t;
      rk[95:64] ^= rk[127:96];
      rk[63:32] ^= rk[95:64];
      rk[31:0] ^= rk[63:32];
      rc = mul2(rc);
      // subbytes with shiftrows, byte index = col*4 + row
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) sh[c*4+w] = sb[st[((c + w) % 4)*4 + w]];
      for (int c = 0; c < 4; c++) begin
        if (r < 10) begin
          for (int w = 0; w < 4; w++)
            st[c*4+w] = gmul(sh[c*4+w], 8'h02) ^ gmul(sh[c*4+(w+1)%4], 8'h03) ^
                        sh[c*4+(w+2)%4] ^ sh[c*4+(w+3)%4];
        end else begin
          for (int w = 0; w < 4; w++) st[c*4+w] = sh[c*4+w];
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = st[i];
    return o;
  endfunction

  // expected output item for one accepted block, advances the counter
  function automatic logic [135:0] ctr_crypt(blk_t b);
    logic [127:0] ks, blk, msk;
    logic [4:0]   n;
    n = b.data[132:128];
    if (n > 5'd16) n = 5'd16;
    if (b.first) ctr = {ctr_init_hi, ctr_init_lo};
    ks = keystream({key_hi, key_lo}, ctr);
    // byte 0 is the top byte of data_high
    blk = {b.data[63:0], b.data[127:64]} ^ ks;
    for (int i = 0; i < 16; i++) msk[127-8*i -: 8] = (i < n) ? 8'hff : 8'h00;
    blk &= msk;
    ctr = ctr + 128'd1;
    return {3'b000, n, blk[63:0], blk[127:64]};
  endfunction

  task automatic write_reg(aes_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aes_pkg::REG_KEY_HIGH: key_hi = val;
      aes_pkg::REG_KEY_LOW:  key_lo = val;
      aes_pkg::REG_CTR_HIGH: ctr_init_hi = val;
      aes_pkg::REG_CTR_LOW:  ctr_init_lo = val;
      default: ;
    endcase
  endtask

  // wait until the engine has drained and the driver has nothing in flight
  task automatic drain();
    while (pending_blocks.size() != 0 || expected_results.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] n, logic f);
    blk_t b;
    b.data = {3'b000, n, lo, hi};
    b.first = f;
    pending_blocks = {pending_blocks, b};
  endtask

  // random stream: message runs starting with first_block, sometimes a random count at the end
  task automatic push_messages(int count);
    int len;
    logic [4:0] n;
    while (count > 0) begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len && count > 0; i++, count--) begin
        n = 5'd16;
        if (i == len - 1 && $urandom_range(0, 2) == 0) n = 5'($urandom_range(0, 31));
        else if ($urandom_range(0, 19) == 0) n = 5'($urandom_range(0, 31));
        push_block(rand64(), rand64(), n, (i == 0) || ($urandom_range(0, 49) == 0));
      end
    end
  endtask

  // driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid)
          expected_results = {expected_results, ctr_crypt('{in_tdata, in_tuser})};
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          in_tdata <= pending_blocks[0].data;
          in_tuser <= pending_blocks[0].first;
          in_tvalid <= 1'b1;
          void'(pending_blocks.pop_front());
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: phases of always-ready, random and sparse readiness
  int stall_phase = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_phase <= $urandom_range(0, 2);
    if (hold_off) out_tready <= 1'b0;
    else case (stall_phase)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: compare each result with the oldest expectation
  logic [135:0] exp_res;
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected item: %h", out_tdata);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata[63:0] !== exp_res[63:0] || out_tdata[127:64] !== exp_res[127:64] ||
            out_tdata[132:128] !== exp_res[132:128] || out_tdata[135:133] !== 3'b000) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: hi exp %h got %h, lo exp %h got %h, bytes exp %0d got %0d",
                     exp_res[63:0], out_tdata[63:0], exp_res[127:64], out_tdata[127:64],
                     exp_res[132:128], out_tdata[132:128]);
        end
      end
    end
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout: no progress");
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] inv, x;
    // s-box: inverse in gf(2^8) followed by the affine transform
    for (int a = 0; a < 256; a++) begin
      inv = 0;
      for (int b = 1; b < 256; b++) if (gmul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      x = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      sb[a] = x;
    end
    key_hi = 0; key_lo = 0; ctr_init_hi = 0; ctr_init_lo = 0; ctr = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and zero counter, including a stream with no first_block
    push_block(64'h0, 64'h0, 5'd16, 1'b0);
    push_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd16, 1'b0);
    drain();

    // fips-197 style key, every valid count and the saturation cases
    write_reg(aes_pkg::REG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
    write_reg(aes_pkg::REG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
    write_reg(aes_pkg::REG_CTR_HIGH, 64'hf0f1_f2f3_f4f5_f6f7);
    write_reg(aes_pkg::REG_CTR_LOW, 64'hf8f9_fafb_fcfd_feff);
    push_block(64'h6bc1_bee2_2e40_9f96, 64'he93d_7e11_7393_172a, 5'd16, 1'b1);
    for (int n = 0; n <= 17; n++)
      push_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'(n), 1'b0);
    push_block(rand64(), rand64(), 5'd31, 1'b0);
    push_block(rand64(), rand64(), 5'd8, 1'b1);
    drain();

    // counter wrap from all ones to zero, and low-half carry
    write_reg(aes_pkg::REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(aes_pkg::REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    write_reg(aes_pkg::REG_CTR_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(aes_pkg::REG_CTR_LOW, 64'hffff_ffff_ffff_fffe);
    push_block(64'h0, 64'h0, 5'd16, 1'b1);
    push_block(64'h0, 64'h0, 5'd16, 1'b0);
    push_block(64'h0, 64'h0, 5'd16, 1'b0);
    drain();
    write_reg(aes_pkg::REG_CTR_HIGH, 64'h0);
    write_reg(aes_pkg::REG_CTR_LOW, 64'hffff_ffff_ffff_ffff);
    push_block(rand64(), rand64(), 5'd16, 1'b1);
    push_block(rand64(), rand64(), 5'd16, 1'b0);
    drain();

    // random phases under random keys and counters
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(aes_pkg::REG_KEY_HIGH, rand64());
      write_reg(aes_pkg::REG_KEY_LOW, rand64());
      write_reg(aes_pkg::REG_CTR_HIGH, (ph == 2) ? 64'hffff_ffff_ffff_ffff : rand64());
      write_reg(aes_pkg::REG_CTR_LOW, (ph == 2) ? 64'hffff_ffff_ffff_ffe0 : rand64());
      if (ph == 3) begin
        // long receiver hold-off while the sender keeps offering items
        hold_off = 1'b1;
        push_messages(300);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        push_messages(300);
      end
      drain();
    end

    $display("covered %0d results over directed vectors, counter wrap and six random phases",
             results_seen);
    $display("valid counts 0..31, reloads mid-stream and a long output stall included");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
